// ===== hdl/crcfr_pkg.sv =====
// Shared types and constants of the CRC-16 framed receiver.
// No dependencies; the controller, datapath and top level refer to it by scoped names.
`timescale 1ns / 1ps

package crcfr_pkg;

  localparam int unsigned FrameBytes   = 13;
  localparam int unsigned CheckedBytes = 11;
  localparam int unsigned CrcBits      = CheckedBytes * 8;
  localparam int unsigned FillWidth    = $clog2(FrameBytes + 1);
  localparam int unsigned BitCntWidth  = $clog2(CrcBits);

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  SyncReset = 8'h02;

  typedef logic [FillWidth-1:0]   fill_t;
  typedef logic [BitCntWidth-1:0] bit_cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CRC,
    ST_REPORT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store_byte;
    logic drop_oldest;
    logic clear_window;
    logic crc_clear;
    logic crc_step;
    logic load_result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fill_last;
    logic sync_match;
    logic crc_last;
    logic crc_match;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hdl/crcfr_in_if.sv =====
// Input channel of the CRC-16 framed receiver: one received byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/crcfr_out_if.sv =====
// Result channel of the CRC-16 framed receiver: decoded frame or CRC error flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface crcfr_out_if;
  logic               valid;
  logic               ready;
  logic               frame_valid;
  logic               crc_error;
  logic [15:0]        adc_zero;
  logic [15:0]        adc_one;
  logic [15:0]        adc_two;
  logic [7:0]         input_bits;
  logic signed [7:0]  temperature;
  logic [15:0]        pressure;

  modport source (output valid, output frame_valid, output crc_error, output adc_zero,
                  output adc_one, output adc_two, output input_bits, output temperature,
                  output pressure, input ready);
  modport sink   (input valid, input frame_valid, input crc_error, input adc_zero,
                  input adc_one, input adc_two, input input_bits, input temperature,
                  input pressure, output ready);
endinterface

// ===== hdl/crcfr_ctrl.sv =====
// Controller of the CRC-16 framed receiver: sequences byte intake, sync check,
// the bit-serial CRC pass and the report. Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  crcfr_pkg::ctrl_sts_t  sts_i,
  output crcfr_pkg::ctrl_cmd_t  cmd_o
);

  crcfr_pkg::state_e state_q, state_d;
  logic              in_accept;

  assign in_accept = in_valid_i && (state_q == crcfr_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crcfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      crcfr_pkg::ST_IDLE: begin
        if (in_accept && sts_i.fill_last) state_d = crcfr_pkg::ST_CHECK;
      end
      crcfr_pkg::ST_CHECK: begin
        state_d = sts_i.sync_match ? crcfr_pkg::ST_CRC : crcfr_pkg::ST_IDLE;
      end
      crcfr_pkg::ST_CRC: begin
        if (sts_i.crc_last) state_d = crcfr_pkg::ST_REPORT;
      end
      crcfr_pkg::ST_REPORT: begin
        if (sts_i.out_free) state_d = crcfr_pkg::ST_IDLE;
      end
      default: state_d = crcfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      crcfr_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.store_byte = in_valid_i;
      end
      crcfr_pkg::ST_CHECK: begin
        // header mismatch: drop the oldest byte and report nothing
        cmd_o.crc_clear   = sts_i.sync_match;
        cmd_o.drop_oldest = !sts_i.sync_match;
      end
      crcfr_pkg::ST_CRC: begin
        cmd_o.crc_step = 1'b1;
      end
      crcfr_pkg::ST_REPORT: begin
        // hold until the result register is free
        cmd_o.load_result  = sts_i.out_free;
        cmd_o.clear_window = sts_i.out_free && sts_i.crc_match;
        cmd_o.drop_oldest  = sts_i.out_free && !sts_i.crc_match;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/crcfr_datapath.sv =====
// Datapath of the CRC-16 framed receiver: byte window, sync register, bit-serial
// CRC-16 unit and the result register. Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  out_ready_i,
  input  crcfr_pkg::ctrl_cmd_t  cmd_i,
  output crcfr_pkg::ctrl_sts_t  sts_o,
  output logic                  out_valid_o,
  output logic                  frame_valid_o,
  output logic                  crc_error_o,
  output logic [15:0]           adc_zero_o,
  output logic [15:0]           adc_one_o,
  output logic [15:0]           adc_two_o,
  output logic [7:0]            input_bits_o,
  output logic signed [7:0]     temperature_o,
  output logic [15:0]           pressure_o
);

  logic [7:0]          window_q [crcfr_pkg::FrameBytes];
  crcfr_pkg::fill_t    fill_q;
  logic [7:0]          sync_q;
  logic [15:0]         crc_q, crc_d;
  crcfr_pkg::bit_cnt_t bit_q;
  logic [7:0]          crc_byte;
  logic [15:0]         crc_mix;
  logic                out_valid_q;
  logic                pass;

  // bits [6:3] of the step count select the byte being folded in
  assign crc_byte = window_q[bit_q[crcfr_pkg::BitCntWidth-1:3]];
  assign crc_mix  = (bit_q[2:0] == 3'd0) ? (crc_q ^ {8'h00, crc_byte}) : crc_q;
  assign crc_d    = crc_mix[0] ? ((crc_mix >> 1) ^ crcfr_pkg::CrcPoly) : (crc_mix >> 1);
  assign pass     = (crc_q == {window_q[12], window_q[11]});

  assign sts_o.fill_last  = (fill_q == crcfr_pkg::fill_t'(crcfr_pkg::FrameBytes - 1));
  assign sts_o.sync_match = (window_q[0] == sync_q);
  assign sts_o.crc_last   = (bit_q == crcfr_pkg::bit_cnt_t'(crcfr_pkg::CrcBits - 1));
  assign sts_o.crc_match  = pass;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      window_q[fill_q] <= rx_byte_i;
    end else if (cmd_i.drop_oldest) begin
      for (int i = 0; i < crcfr_pkg::FrameBytes - 1; i++) begin
        window_q[i] <= window_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sync_q <= crcfr_pkg::SyncReset;
      crc_q  <= crcfr_pkg::CrcInit;
      bit_q  <= '0;
    end else begin
      if (cfg_we_i) sync_q <= cfg_data_i;
      if (cmd_i.store_byte) begin
        fill_q <= fill_q + 1'b1;
      end else if (cmd_i.drop_oldest) begin
        fill_q <= crcfr_pkg::fill_t'(crcfr_pkg::FrameBytes - 1);
      end else if (cmd_i.clear_window) begin
        fill_q <= '0;
      end
      if (cmd_i.crc_clear) begin
        crc_q <= crcfr_pkg::CrcInit;
        bit_q <= '0;
      end else if (cmd_i.crc_step) begin
        crc_q <= crc_d;
        bit_q <= bit_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // a failed check reports zero data fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      frame_valid_o <= pass;
      crc_error_o   <= !pass;
      adc_zero_o    <= pass ? {window_q[2], window_q[1]} : 16'h0000;
      adc_one_o     <= pass ? {window_q[4], window_q[3]} : 16'h0000;
      adc_two_o     <= pass ? {window_q[6], window_q[5]} : 16'h0000;
      input_bits_o  <= pass ? window_q[7] : 8'h00;
      temperature_o <= pass ? $signed(window_q[8]) : 8'sh00;
      pressure_o    <= pass ? {window_q[9], window_q[10]} : 16'h0000;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/crc16_frame_receiver_core.sv =====
// Top level of the CRC-16 framed receiver: controller plus datapath.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if, crcfr_ctrl, crcfr_datapath.
//
// Usage:
//   in_i carries one received byte per transaction. Bytes fill a 13-byte window.
//   When the window is full and its first byte equals the sync register, a
//   reflected CRC-16 (init FFFF, polynomial A001) runs over bytes 0..10, one bit
//   per cycle, and is compared with the little-endian trailer in bytes 11..12.
//   out_o then carries one transaction: decoded fields with frame_valid set, or
//   crc_error set with all data fields zero. A header mismatch drops the oldest
//   byte silently; a CRC mismatch drops it after the error report.
//   Timing: a byte that does not complete the window is taken while idle. A
//   full window with a wrong header goes from check back to intake; a synced
//   window goes through intake, check, the bit-serial CRC steps and report.
//   The result register decouples the two sides: intake resumes while a result
//   waits, and only the next report holds until out_o is taken.
//   Reset empties the window, loads 0x02 into the sync register and clears the
//   result valid flag. cfg_we_i writes cfg_data_i into the sync register.
`timescale 1ns / 1ps

module crc16_frame_receiver_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  crcfr_in_if.sink          in_i,
  crcfr_out_if.source       out_o
);

  crcfr_pkg::ctrl_cmd_t cmd;
  crcfr_pkg::ctrl_sts_t sts;

  crcfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crcfr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (in_i.rx_byte),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .frame_valid_o (out_o.frame_valid),
    .crc_error_o   (out_o.crc_error),
    .adc_zero_o    (out_o.adc_zero),
    .adc_one_o     (out_o.adc_one),
    .adc_two_o     (out_o.adc_two),
    .input_bits_o  (out_o.input_bits),
    .temperature_o (out_o.temperature),
    .pressure_o    (out_o.pressure)
  );

endmodule

// ===== hdl/crcfr_checker.sv =====
// Port-level checks of the CRC-16 framed receiver, bound to its top level.
// Depends on crc16_frame_receiver_core and its interfaces.
`timescale 1ns / 1ps

module crcfr_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_ready_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              frame_valid_i,
  input  logic              crc_error_i,
  input  logic [15:0]       adc_zero_i,
  input  logic [15:0]       adc_one_i,
  input  logic [15:0]       adc_two_i,
  input  logic [7:0]        input_bits_i,
  input  logic signed [7:0] temperature_i,
  input  logic [15:0]       pressure_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_valid_i)
      && $stable(adc_zero_i) && $stable(pressure_i))
    else $error("result changed while stalled");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_valid_i != crc_error_i))
    else $error("result must be either a frame or a CRC error");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && crc_error_i |-> adc_zero_i == 16'h0000 && adc_one_i == 16'h0000
      && adc_two_i == 16'h0000 && input_bits_i == 8'h00 && temperature_i == 8'sh00
      && pressure_i == 16'h0000)
    else $error("CRC error report carries nonzero data");

  // a new result only comes out of the report step, where intake is closed
  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while intake was open");

endmodule

bind crc16_frame_receiver_core crcfr_checker u_crcfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .frame_valid_i (out_o.frame_valid),
  .crc_error_i   (out_o.crc_error),
  .adc_zero_i    (out_o.adc_zero),
  .adc_one_i     (out_o.adc_one),
  .adc_two_i     (out_o.adc_two),
  .input_bits_i  (out_o.input_bits),
  .temperature_i (out_o.temperature),
  .pressure_i    (out_o.pressure)
);
